// ===== rtl/modbus_rtu_read_holding_responder_defines.svh =====
// Assertion macros for the Modbus read-holding responder.
`ifndef MODBUS_RTU_READ_HOLDING_RESPONDER_DEFINES_SVH
`define MODBUS_RTU_READ_HOLDING_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MBRH_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("mbrh assertion failed");

// next-cycle implication
`define MBRH_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("mbrh assertion failed");

`else

`define MBRH_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define MBRH_ASSERT_NXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== rtl/mbrh_pkg.sv =====
// Shared types, constants and CRC function for the Modbus read-holding responder.
package mbrh_pkg;

  localparam int FRAME_LEN_DEF = 8;
  localparam int REG_COUNT_DEF = 64;
  localparam int MAX_REGS_DEF  = 16;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  SLAVE_ID_RST      = 8'd1;

  // request frame byte positions
  localparam logic [3:0] BYTE_ID    = 4'd0;
  localparam logic [3:0] BYTE_FUNC  = 4'd1;
  localparam logic [3:0] BYTE_START = 4'd3;
  localparam logic [3:0] BYTE_COUNT = 4'd5;

  // input word kinds
  localparam logic CMD_RX_BYTE   = 1'b0;
  localparam logic CMD_REG_WRITE = 1'b1;

  typedef struct packed {
    logic       go;
    logic [7:0] start;
    logic [6:0] count;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_HI,
    ST_LO,
    ST_CRCL,
    ST_CRCH
  } tx_state_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mbrh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mbrh_rx.sv =====
// Request frame assembly: write position, kept frame bytes and request decode.
module mbrh_rx
  import mbrh_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF,
  parameter int MAX_REGS  = MAX_REGS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  input  logic [7:0] slave_id,
  output req_t       req
);

  localparam logic [4:0] FrameLen = 5'(FRAME_LEN);
  localparam logic [8:0] RegCount = 9'(REG_COUNT);
  localparam logic [8:0] MaxRegs  = 9'(MAX_REGS);

  logic [3:0] wpos_r, wpos_nxt;
  logic [7:0] b0_r, b0_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic [7:0] b3_r, b3_nxt;
  logic [7:0] b5_r, b5_nxt;
  logic [3:0] pos, np;
  logic       match, done, valid_req;
  logic [8:0] span;

  always_comb begin
    pos    = ({1'b0, wpos_r} >= FrameLen) ? 4'd0 : wpos_r;
    np     = pos + 4'd1;
    b0_nxt = (pos == BYTE_ID)    ? rx_byte : b0_r;
    b1_nxt = (pos == BYTE_FUNC)  ? rx_byte : b1_r;
    b3_nxt = (pos == BYTE_START) ? rx_byte : b3_r;
    b5_nxt = (pos == BYTE_COUNT) ? rx_byte : b5_r;
    match  = (b0_nxt == slave_id);
    // 4-bit position wraps to zero when the frame is sixteen bytes long
    done   = (np == 4'd0) || ({1'b0, np} >= FrameLen);
    wpos_nxt = (!match || done) ? 4'd0 : np;
    span   = {1'b0, b3_nxt} + {1'b0, b5_nxt};
    valid_req = (b1_nxt == FUNC_READ_HOLDING) && (b5_nxt != 8'd0) &&
                ({1'b0, b5_nxt} <= MaxRegs) && (span <= RegCount);
    req.go    = byte_en && match && done && valid_req;
    req.start = b3_nxt;
    req.count = b5_nxt[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= 4'd0;
      b0_r   <= 8'd0;
      b1_r   <= 8'd0;
      b3_r   <= 8'd0;
      b5_r   <= 8'd0;
    end else if (byte_en) begin
      wpos_r <= wpos_nxt;
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
      b3_r   <= b3_nxt;
      b5_r   <= b5_nxt;
    end
  end

endmodule

// ===== rtl/mbrh_tx.sv =====
// Response sequencer: header, register reads from the table RAM, CRC and output register.
`include "modbus_rtu_read_holding_responder_defines.svh"

module mbrh_tx
  import mbrh_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF,
  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    slave_id,
  input  req_t          req,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [15:0]   rd_data,
  output logic          idle,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  localparam logic [1:0] HDR_ID   = 2'd0;
  localparam logic [1:0] HDR_FUNC = 2'd1;

  tx_state_t     state_r, state_nxt;
  logic [1:0]    hdr_r, hdr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [6:0]    count_r, count_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_last_r;
  logic          slot, load, feed, last_nxt;
  logic [7:0]    byte_nxt;

  assign slot = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hdr_nxt   = hdr_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    count_nxt = count_r;
    load      = 1'b0;
    feed      = 1'b0;
    last_nxt  = 1'b0;
    byte_nxt  = 8'd0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.go) begin
          state_nxt = ST_HDR;
          hdr_nxt   = HDR_ID;
          addr_nxt  = req.start[AW-1:0];
          rem_nxt   = req.count;
          count_nxt = req.count;
        end
      end
      ST_HDR: begin
        if (slot) begin
          load = 1'b1;
          feed = 1'b1;
          case (hdr_r)
            HDR_ID:   byte_nxt = slave_id;
            HDR_FUNC: byte_nxt = FUNC_READ_HOLDING;
            default:  byte_nxt = {count_r, 1'b0};
          endcase
          if (hdr_r == HDR_ID || hdr_r == HDR_FUNC) begin
            hdr_nxt = hdr_r + 2'd1;
          end else begin
            // fetch the first register while the byte count goes out
            rd_en     = 1'b1;
            state_nxt = ST_HI;
          end
        end
      end
      ST_HI: begin
        if (slot) begin
          load      = 1'b1;
          feed      = 1'b1;
          byte_nxt  = rd_data[15:8];
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        if (slot) begin
          load     = 1'b1;
          feed     = 1'b1;
          byte_nxt = rd_data[7:0];
          rem_nxt  = rem_r - 7'd1;
          if (rem_r == 7'd1) begin
            state_nxt = ST_CRCL;
          end else begin
            rd_en     = 1'b1;
            addr_nxt  = addr_r + AW'(1);
            state_nxt = ST_HI;
          end
        end
      end
      ST_CRCL: begin
        if (slot) begin
          load      = 1'b1;
          byte_nxt  = crc_r[7:0];
          state_nxt = ST_CRCH;
        end
      end
      ST_CRCH: begin
        if (slot) begin
          load      = 1'b1;
          byte_nxt  = crc_r[15:8];
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE) begin
      crc_nxt = CRC_INIT;
    end else if (feed) begin
      crc_nxt = crc_feed(crc_r, byte_nxt);
    end else begin
      crc_nxt = crc_r;
    end
  end

  assign rd_addr = addr_nxt;
  assign idle    = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    addr_r  <= addr_nxt;
    rem_r   <= rem_nxt;
    count_r <= count_nxt;
    crc_r   <= crc_nxt;
    if (load) begin
      out_data_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `MBRH_ASSERT_IMP(a_go_when_idle, clk, rst_n, req.go, state_r == ST_IDLE)
  `MBRH_ASSERT_IMP(a_read_only_busy, clk, rst_n, rd_en, state_r != ST_IDLE)
  `MBRH_ASSERT_NXT(a_last_ends_frame, clk, rst_n, load && last_nxt, state_r == ST_IDLE)

endmodule

// ===== rtl/modbus_rtu_read_holding_responder.sv =====
// Top level of the Modbus RTU read-holding-registers responder.
//
//  channel | dir | data                                              | side band
//  in_     | in  | tdata: rx_byte[7:0] reg_index[13:8] reg_value[29:14] | tuser: cmd
//  out_    | out | tdata: tx_byte[7:0]                               | tlast: last_byte
//  cfg_    | in  | wdata: slave_id[7:0], written when cfg_we is high  | -
//
// Received bytes and register writes wait for in_tready, which is high while no
// response is being generated. A complete valid request produces 5 + 2*count bytes
// at one byte per cycle when out_tready stays high: the register table RAM read
// for each register is issued while the previous byte leaves, so the sequencer
// sets the figure. Reset clears the table through per-entry valid bits, no sweep.
// out_tready low stalls the sequencer; input stays blocked until the last byte is
// in the output register.
`include "modbus_rtu_read_holding_responder_defines.svh"

module modbus_rtu_read_holding_responder
  import mbrh_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF,
  parameter int MAX_REGS  = MAX_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte, reg_index, reg_value, zero pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0] RegCount = 9'(REG_COUNT);

  logic [7:0]     slave_id_r;
  logic           accept, byte_en;
  logic [8:0]     widx;
  logic           ram_we;
  logic [AW-1:0]  waddr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [15:0]    ram_q, rd_data;
  logic           rd_valid_r;
  logic [REG_COUNT-1:0] valid_r;
  logic           idle;
  req_t           req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= SLAVE_ID_RST;
    end else if (cfg_we) begin
      slave_id_r <= cfg_wdata;
    end
  end

  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;
  assign byte_en   = accept && (in_tuser == CMD_RX_BYTE);
  assign widx      = {3'b000, in_tdata[13:8]};
  assign ram_we    = accept && (in_tuser == CMD_REG_WRITE) && (widx < RegCount);
  assign waddr     = widx[AW-1:0];

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? ram_q : 16'd0;

  mbrh_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_tdata[29:14]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  mbrh_rx #(
    .FRAME_LEN (FRAME_LEN),
    .REG_COUNT (REG_COUNT),
    .MAX_REGS  (MAX_REGS)
  ) u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .rx_byte  (in_tdata[7:0]),
    .slave_id (slave_id_r),
    .req      (req)
  );

  mbrh_tx #(
    .REG_COUNT (REG_COUNT)
  ) u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .slave_id   (slave_id_r),
    .req        (req),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .idle       (idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // table writes and response reads never share a cycle
  `MBRH_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ram_we, !rd_en)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Modbus RTU read-holding-registers responder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrh_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // rx_byte, reg_index, reg_value, zero pad
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // tx_byte
  logic        out_tlast;       // last_byte
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // mirror of the responder's state
  logic [7:0]  id_mirror = SLAVE_ID_RST;
  logic [7:0]  frame_mirror [FRAME_LEN_DEF] = '{default: '0};
  logic [3:0]  pos_mirror = '0;
  logic [15:0] table_mirror [REG_COUNT_DEF] = '{default: '0};
  logic [15:0] reply_crc;

  reply_byte_t reply_queue [$];
  int          fail_count = 0;
  bit          calm = 1'b0;

  modbus_rtu_read_holding_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_reply_byte(input logic [7:0] b);
    reply_queue.push_back('{tx_byte: b, last_byte: 1'b0});
    reply_crc = reply_crc ^ {8'h00, b};
    repeat (8) begin
      if (reply_crc[0]) reply_crc = {1'b0, reply_crc[15:1]} ^ CRC_POLY;
      else reply_crc = {1'b0, reply_crc[15:1]};
    end
  endfunction

  // Advance the mirror by one accepted word and queue any response bytes.
  function automatic void absorb_word(input logic cmd, input logic [7:0] rx,
                                      input logic [5:0] idx, input logic [15:0] val);
    logic [7:0] start;
    logic [7:0] count;
    if (cmd == CMD_REG_WRITE) begin
      if (int'(idx) < REG_COUNT_DEF) table_mirror[idx] = val;
      return;
    end
    if (int'(pos_mirror) >= FRAME_LEN_DEF) pos_mirror = '0;
    frame_mirror[pos_mirror] = rx;
    pos_mirror = pos_mirror + 4'd1;
    if (frame_mirror[BYTE_ID] != id_mirror) begin
      pos_mirror = '0;
      return;
    end
    if (pos_mirror != 4'd0 && int'(pos_mirror) < FRAME_LEN_DEF) return;
    pos_mirror = '0;
    start = frame_mirror[BYTE_START];
    count = frame_mirror[BYTE_COUNT];
    if (frame_mirror[BYTE_FUNC] != FUNC_READ_HOLDING) return;
    if (count == 8'd0 || int'(count) > MAX_REGS_DEF ||
        int'(start) + int'(count) > REG_COUNT_DEF) return;
    reply_crc = CRC_INIT;
    push_reply_byte(id_mirror);
    push_reply_byte(FUNC_READ_HOLDING);
    push_reply_byte(8'(count * 2));
    for (int k = 0; k < int'(count); k++) begin
      push_reply_byte(table_mirror[int'(start) + k][15:8]);
      push_reply_byte(table_mirror[int'(start) + k][7:0]);
    end
    reply_queue.push_back('{tx_byte: reply_crc[7:0], last_byte: 1'b0});
    reply_queue.push_back('{tx_byte: reply_crc[15:8], last_byte: 1'b1});
  endfunction

  // Result checker: every output word against the oldest expected byte.
  always @(posedge clk) begin : reply_check
    reply_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_queue.size() == 0) begin
        $display("%0t: unexpected word tx_byte %02h last %0b", $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = reply_queue.pop_front();
        if (out_tdata !== want.tx_byte) begin
          $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                   $time, want.tx_byte, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last_byte) begin
          $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                   $time, want.last_byte, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Receiver pacing: stretches of ready, bursts of stall.
  initial begin : sink_pacing
    int run_len;
    run_len = 1;
    forever begin
      repeat (run_len) @(posedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        run_len = $urandom_range(1, 30);
      end else begin
        out_tready <= 1'b0;
        run_len = $urandom_range(1, 18);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input logic cmd, input logic [7:0] rx,
                           input logic [5:0] idx, input logic [15:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, val, idx, rx};
    do @(posedge clk); while (!in_tready);
    absorb_word(cmd, rx, idx, val);
  endtask

  task automatic send_rx(input logic [7:0] rx);
    send_word(CMD_RX_BYTE, rx, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_reg_write(input logic [5:0] idx, input logic [15:0] val);
    send_word(CMD_REG_WRITE, 8'($urandom), idx, val);
  endtask

  // Header bytes two, four and the CRC are filled with random content.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] func,
                            input logic [7:0] start, input logic [7:0] count);
    send_rx(id);
    send_rx(func);
    send_rx(8'($urandom));
    send_rx(start);
    send_rx(8'($urandom));
    send_rx(count);
    send_rx(8'($urandom));
    send_rx(8'($urandom));
  endtask

  // Finish any partial frame so the next one starts at byte zero.
  task automatic realign_frame();
    while (pos_mirror != 4'd0) send_rx(8'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_slave_id(input logic [7:0] id);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we    <= 1'b0;
    id_mirror = id;
  endtask

  task automatic test_register_write_extremes();
    send_reg_write(6'd0, 16'hFFFF);
    send_reg_write(6'd63, 16'hFFFF);
    send_reg_write(6'd48, 16'h8000);
  endtask

  // Largest response: 16 registers ending at the top of the table.
  task automatic test_table_tail_read();
    send_frame(id_mirror, FUNC_READ_HOLDING, 8'd48, 8'd16);
  endtask

  // Byte zero stored under the old id no longer matches once the id changes.
  task automatic test_stale_slave_id();
    send_rx(id_mirror);
    send_rx(FUNC_READ_HOLDING);
    send_rx(8'h00);
    set_slave_id(8'h09);
    send_rx(8'h00);
    send_frame(8'h09, FUNC_READ_HOLDING, 8'd0, 8'd2);
    set_slave_id(8'd1);
  endtask

  task automatic test_random_traffic(input int quota);
    int done;
    int pick;
    logic [7:0] id;
    logic [7:0] func;
    logic [7:0] start;
    logic [7:0] count;
    logic [15:0] val;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        realign_frame();
        id   = ($urandom_range(0, 19) == 0) ? 8'($urandom) : id_mirror;
        func = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_READ_HOLDING;
        case ($urandom_range(0, 11))
          0: begin
            count = 8'd0;
            start = 8'($urandom_range(0, REG_COUNT_DEF - 1));
          end
          1: begin
            count = 8'($urandom_range(MAX_REGS_DEF + 1, 255));
            start = 8'($urandom);
          end
          2: begin
            // runs past the end of the table
            count = 8'($urandom_range(1, MAX_REGS_DEF));
            start = 8'($urandom_range(REG_COUNT_DEF - int'(count) + 1, 255));
          end
          default: begin
            count = 8'($urandom_range(1, MAX_REGS_DEF));
            start = 8'($urandom_range(0, REG_COUNT_DEF - int'(count)));
          end
        endcase
        send_frame(id, func, start, count);
        done += 8;
      end else if (pick < 77) begin
        case ($urandom_range(0, 5))
          0: val = 16'hFFFF;
          1: val = 16'h0000;
          default: val = 16'($urandom);
        endcase
        send_reg_write(6'($urandom), val);
        done++;
      end else if (pick < 88) begin
        send_rx(8'($urandom));
      end else if (pick < 97) begin
        // truncated frame, completed by noise later
        realign_frame();
        send_rx(id_mirror);
        repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_register_write_extremes();
    test_table_tail_read();
    test_stale_slave_id();
    test_random_traffic(140);
    set_slave_id(8'd247);
    test_random_traffic(120);
    set_slave_id(8'($urandom_range(2, 246)));
    calm = 1'b1;
    test_random_traffic(100);
    in_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
